// ===== rtl/core/asym_pkg.sv =====
package asym_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int SIZE_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_METHOD = 2'd2,
    REG_SPARE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    METH_GDF     = 2'd0,
    METH_REFINED = 2'd1,
    METH_REF_EXC = 2'd2,
    METH_ALT_GDF = 2'd3
  } method_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_G_CELL,
    S_G_NB,
    S_FIN1,
    S_FIN2,
    S_R_CELL,
    S_R_UP,
    S_R_DN,
    S_R_DEC,
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/asym_if.sv =====
interface asym_in_if import asym_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MAX_COLS-1:0] source_row;
  logic [MAX_COLS-1:0] target_row;
  logic                final_row;
  modport source (output valid, source_row, target_row, final_row, input ready);
  modport sink   (input valid, source_row, target_row, final_row, output ready);
endinterface

interface asym_out_if import asym_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MAX_COLS-1:0] result_row;
  logic [ROW_W-1:0]    row_index;
  logic                last_of_run;
  modport source (output valid, result_row, row_index, last_of_run, input ready);
  modport sink   (input valid, result_row, row_index, last_of_run, output ready);
endinterface

interface asym_cfg_if import asym_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/alignment_symmetrizer.sv =====
// loading: one row pair per cycle, ready is high whenever the block is idle
// after the final row: the intersection is built row by row, then growth passes scan
// every cell (grow-diag-final visits the neighbors of each set cell, refined reads the rows above and
// below each candidate next to an aligned line), two final passes (grow-diag-final modes), r result rows
// one shared row read/modify/write port over the work matrix sets the pace
// rst_n is synchronous: clears control, counts and flags, restores config defaults; matrices undefined until loaded
module alignment_symmetrizer import asym_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  asym_in_if.sink     in_ch,
  asym_out_if.source  out_ch,
  asym_cfg_if.sink    cfg_ch
);

  // configuration registers
  logic [SIZE_W-1:0] rows_cfg_r, cols_cfg_r;
  method_t           method_r;

  // matrix storage, one read row address per cycle
  logic [MAX_COLS-1:0] fm_r [MAX_ROWS];
  logic [MAX_COLS-1:0] sm_r [MAX_ROWS];
  logic [MAX_COLS-1:0] wm_r [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_fl_r;
  logic [MAX_COLS-1:0] col_fl_r;

  state_t            st_r, st_nxt;
  logic [ROW_W-1:0]  i_r, i_nxt;
  logic [COL_W-1:0]  j_r, j_nxt;
  logic [1:0]        di_r, di_nxt, dj_r, dj_nxt;
  logic              up_r, up_nxt, dn_r, dn_nxt;
  logic              changed_r, changed_nxt;
  logic [SIZE_W-1:0] ld_cnt_r, ld_cnt_nxt;

  // effective sizes, zero acts as one and large values saturate
  logic [SIZE_W-1:0]   rows_eff, cols_eff;
  logic [ROW_W-1:0]    rm1;
  logic [COL_W-1:0]    cm1;
  logic [MAX_COLS-1:0] col_mask;
  logic                refined, exclude;

  always_comb begin
    rows_eff = rows_cfg_r;
    if (rows_cfg_r == '0) rows_eff = SIZE_W'(1);
    else if (rows_cfg_r > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
    cols_eff = cols_cfg_r;
    if (cols_cfg_r == '0) cols_eff = SIZE_W'(1);
    else if (cols_cfg_r > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
  end

  assign rm1      = ROW_W'(rows_eff - SIZE_W'(1));
  assign cm1      = COL_W'(cols_eff - SIZE_W'(1));
  assign col_mask = ~({MAX_COLS{1'b1}} << cols_eff);
  assign refined  = (method_r == METH_REFINED) || (method_r == METH_REF_EXC);
  assign exclude  = (method_r == METH_REF_EXC);

  // shared row port
  logic [ROW_W-1:0]    ra;
  logic [MAX_COLS-1:0] rd_f, rd_s, rd_w, rd_u;
  assign rd_f = fm_r[ra];
  assign rd_s = sm_r[ra];
  assign rd_w = wm_r[ra];
  assign rd_u = (rd_f | rd_s) & col_mask;

  // cell set request at (ra, set_col); only a clear cell counts as a change
  logic             set_req, set_eff, init_we, flag_clr, chg_clr;
  logic [COL_W-1:0] set_col;
  assign set_eff = set_req && !rd_w[set_col];

  logic in_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // neighbor address for grow-diag: offsets coded 0,1,2 for -1,0,+1
  logic [ROW_W+1:0] ip_ext;
  logic [COL_W+1:0] jp_ext;
  logic             nb_ok;
  assign ip_ext = {2'b00, i_r} + {{ROW_W{1'b0}}, di_r} - (ROW_W+2)'(1);
  assign jp_ext = {2'b00, j_r} + {{COL_W{1'b0}}, dj_r} - (COL_W+2)'(1);
  assign nb_ok  = !(di_r == 2'd1 && dj_r == 2'd1)
                  && (ip_ext < (ROW_W+2)'(rows_eff))
                  && (jp_ext < (COL_W+2)'(cols_eff));

  // cell scan order helpers
  logic             cell_step, cell_last;
  logic [ROW_W-1:0] adv_i;
  logic [COL_W-1:0] adv_j;
  state_t           cell_state, pass_next;
  logic             changed_eff;

  assign cell_last   = (j_r == cm1) && (i_r == rm1);
  assign adv_j       = (j_r == cm1) ? '0 : j_r + COL_W'(1);
  assign adv_i       = (j_r == cm1) ? i_r + ROW_W'(1) : i_r;
  assign changed_eff = changed_r || set_eff;

  logic lft, rgt;

  always_comb begin
    st_nxt     = st_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    di_nxt     = di_r;
    dj_nxt     = dj_r;
    up_nxt     = up_r;
    dn_nxt     = dn_r;
    ra         = i_r;
    set_req    = 1'b0;
    set_col    = j_r;
    init_we    = 1'b0;
    flag_clr   = 1'b0;
    chg_clr    = 1'b0;
    cell_step  = 1'b0;
    cell_state = st_r;
    pass_next  = S_OUT;
    lft        = 1'b0;
    rgt        = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc && in_ch.final_row) begin
          i_nxt    = '0;
          flag_clr = 1'b1;
          st_nxt   = S_INIT;
        end
      end
      S_INIT: begin
        // work row = intersection
        init_we = 1'b1;
        if (i_r == rm1) begin
          i_nxt   = '0;
          j_nxt   = '0;
          chg_clr = 1'b1;
          st_nxt  = refined ? S_R_CELL : S_G_CELL;
        end else begin
          i_nxt = i_r + ROW_W'(1);
        end
      end
      S_G_CELL: begin
        cell_state = S_G_CELL;
        pass_next  = changed_eff ? S_G_CELL : S_FIN1;
        if (rd_w[j_r]) begin
          di_nxt = '0;
          dj_nxt = '0;
          st_nxt = S_G_NB;
        end else begin
          cell_step = 1'b1;
        end
      end
      S_G_NB: begin
        // one neighbor per cycle, read-modify-write of its row
        cell_state = S_G_CELL;
        pass_next  = changed_eff ? S_G_CELL : S_FIN1;
        ra      = ip_ext[ROW_W-1:0];
        set_col = jp_ext[COL_W-1:0];
        set_req = nb_ok && (!row_fl_r[ip_ext[ROW_W-1:0]] || !col_fl_r[jp_ext[COL_W-1:0]])
                  && rd_u[jp_ext[COL_W-1:0]];
        if (dj_r == 2'd2) begin
          dj_nxt = '0;
          if (di_r == 2'd2) cell_step = 1'b1;
          else di_nxt = di_r + 2'd1;
        end else begin
          dj_nxt = dj_r + 2'd1;
        end
      end
      S_FIN1: begin
        cell_state = S_FIN1;
        pass_next  = S_FIN2;
        set_req    = (!row_fl_r[i_r] || !col_fl_r[j_r]) && rd_f[j_r];
        cell_step  = 1'b1;
      end
      S_FIN2: begin
        cell_state = S_FIN2;
        pass_next  = S_OUT;
        set_req    = (!row_fl_r[i_r] || !col_fl_r[j_r]) && rd_s[j_r];
        cell_step  = 1'b1;
      end
      S_R_CELL: begin
        cell_state = S_R_CELL;
        pass_next  = changed_eff ? S_R_CELL : S_OUT;
        if (!rd_u[j_r] || rd_w[j_r]) begin
          cell_step = 1'b1;
        end else if (!row_fl_r[i_r] && !col_fl_r[j_r]) begin
          set_req   = 1'b1;
          cell_step = 1'b1;
        end else begin
          st_nxt = S_R_UP;
        end
      end
      S_R_UP: begin
        ra     = i_r - ROW_W'(1);
        up_nxt = (i_r != '0) && rd_w[j_r];
        st_nxt = S_R_DN;
      end
      S_R_DN: begin
        ra     = i_r + ROW_W'(1);
        dn_nxt = (i_r != rm1) && rd_w[j_r];
        st_nxt = S_R_DEC;
      end
      S_R_DEC: begin
        cell_state = S_R_CELL;
        pass_next  = changed_eff ? S_R_CELL : S_OUT;
        lft = (j_r != '0) && rd_w[j_r - COL_W'(1)];
        rgt = (j_r != cm1) && rd_w[j_r + COL_W'(1)];
        if (up_r || dn_r || lft || rgt)
          set_req = !exclude || !((lft || rgt) && (up_r || dn_r));
        cell_step = 1'b1;
      end
      S_OUT: begin
        out_ch.valid = 1'b1;
        if (out_acc) begin
          if (i_r == rm1) begin
            i_nxt  = '0;
            st_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + ROW_W'(1);
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cell_step) begin
      if (cell_last) begin
        i_nxt   = '0;
        j_nxt   = '0;
        st_nxt  = pass_next;
        chg_clr = (pass_next == S_G_CELL) || (pass_next == S_R_CELL);
      end else begin
        i_nxt  = adv_i;
        j_nxt  = adv_j;
        st_nxt = cell_state;
      end
    end
  end

  assign changed_nxt = chg_clr ? 1'b0 : (changed_r || set_eff);

  // load row counter saturates at the matrix depth
  always_comb begin
    ld_cnt_nxt = ld_cnt_r;
    if (in_acc) begin
      if (in_ch.final_row) ld_cnt_nxt = '0;
      else if (!ld_cnt_r[ROW_W]) ld_cnt_nxt = ld_cnt_r + SIZE_W'(1);
    end
  end

  assign out_ch.result_row  = rd_w & col_mask;
  assign out_ch.row_index   = i_r;
  assign out_ch.last_of_run = (i_r == rm1);
  assign cfg_ch.ready       = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      di_r       <= '0;
      dj_r       <= '0;
      up_r       <= 1'b0;
      dn_r       <= 1'b0;
      changed_r  <= 1'b0;
      ld_cnt_r   <= '0;
      row_fl_r   <= '0;
      col_fl_r   <= '0;
      rows_cfg_r <= SIZE_W'(MAX_ROWS);
      cols_cfg_r <= SIZE_W'(MAX_COLS);
      method_r   <= METH_GDF;
    end else begin
      st_r      <= st_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      di_r      <= di_nxt;
      dj_r      <= dj_nxt;
      up_r      <= up_nxt;
      dn_r      <= dn_nxt;
      changed_r <= changed_nxt;
      ld_cnt_r  <= ld_cnt_nxt;
      if (flag_clr) begin
        row_fl_r <= '0;
        col_fl_r <= '0;
      end else if (init_we) begin
        row_fl_r[i_r] <= |(rd_f & rd_s & col_mask);
        col_fl_r      <= col_fl_r | (rd_f & rd_s & col_mask);
      end else if (set_eff) begin
        row_fl_r[ra]      <= 1'b1;
        col_fl_r[set_col] <= 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_ROWS:   rows_cfg_r <= cfg_ch.data;
          REG_COLS:   cols_cfg_r <= cfg_ch.data;
          REG_METHOD: method_r   <= method_t'(cfg_ch.data[1:0]);
          default:    ;
        endcase
      end
    end
  end

  // matrix payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc && !ld_cnt_r[ROW_W]) begin
      fm_r[ld_cnt_r[ROW_W-1:0]] <= in_ch.source_row;
      sm_r[ld_cnt_r[ROW_W-1:0]] <= in_ch.target_row;
    end
    if (init_we) wm_r[ra] <= rd_f & rd_s & col_mask;
    else if (set_eff) wm_r[ra][set_col] <= 1'b1;
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and result channels active together");

  a_ld_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ld_cnt_r <= SIZE_W'(MAX_ROWS))
    else $error("load count beyond depth");

  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.final_row) |=> (st_r == S_INIT) && (ld_cnt_r == '0))
    else $error("final row did not start symmetrization");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last_of_run) |=> (st_r == S_IDLE))
    else $error("block not idle after last result row");

  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_INIT) && (i_r == rm1) |=> !changed_r)
    else $error("change flag not cleared for first pass");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import asym_pkg::*;

  typedef struct packed {
    logic [31:0] source_row;
    logic [31:0] target_row;
    logic        final_row;
  } row_pair_t;

  typedef struct packed {
    logic [31:0] result_row;
    logic [4:0]  row_index;
    logic        last_of_run;
  } sym_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  asym_in_if  in_ch ();
  asym_out_if out_ch ();
  asym_cfg_if cfg_ch ();

  alignment_symmetrizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: loaded matrices, working copy, aligned flags, registers
  logic [31:0] src_mat [32];
  logic [31:0] tgt_mat [32];
  logic [31:0] sym_mat [32];
  logic [31:0] row_flags, col_flags;
  int          load_count;
  logic        grew;
  logic [5:0]  cur_rows, cur_cols;
  method_t     cur_method;

  row_pair_t   pending_rows [$];
  sym_row_t    expected_rows [$];
  int          errors = 0;
  int          rows_seen = 0;
  int          runs_seen = 0;
  bit          calm = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void mark_cell(input int i, input int j);
    if (!sym_mat[i][j]) begin
      sym_mat[i][j] = 1'b1;
      row_flags[i] = 1'b1;
      col_flags[j] = 1'b1;
      grew = 1'b1;
    end
  endfunction

  // symmetrize the loaded matrices and queue the expected result rows
  function automatic void symmetrize_run();
    int r, c, ip, jp;
    logic [31:0] mask, uni;
    bit up, dn, lf, rt;
    sym_row_t er;
    r = (cur_rows < 1) ? 1 : (cur_rows > 32) ? 32 : cur_rows;
    c = (cur_cols < 1) ? 1 : (cur_cols > 32) ? 32 : cur_cols;
    mask = (c == 32) ? 32'hFFFF_FFFF : ((32'd1 << c) - 1);
    row_flags = '0;
    col_flags = '0;
    for (int i = 0; i < r; i++) begin
      sym_mat[i] = src_mat[i] & tgt_mat[i] & mask;
      if (sym_mat[i] != 0) row_flags[i] = 1'b1;
      col_flags |= sym_mat[i];
    end
    if (cur_method == METH_REFINED || cur_method == METH_REF_EXC) begin
      do begin
        grew = 1'b0;
        for (int i = 0; i < r; i++)
          for (int j = 0; j < c; j++) begin
            uni = (src_mat[i] | tgt_mat[i]) & mask;
            if (!uni[j] || sym_mat[i][j]) continue;
            if (!col_flags[j] && !row_flags[i]) begin
              mark_cell(i, j);
              continue;
            end
            up = i > 0 && sym_mat[i-1][j];
            dn = i + 1 < r && sym_mat[i+1][j];
            lf = j > 0 && sym_mat[i][j-1];
            rt = j + 1 < c && sym_mat[i][j+1];
            // exclusion variant rejects cells with both horizontal and vertical support
            if (up || dn || lf || rt)
              if (cur_method != METH_REF_EXC || !((lf || rt) && (up || dn)))
                mark_cell(i, j);
          end
      end while (grew);
    end else begin
      // grow-diag-final, also used for the spare method code
      do begin
        grew = 1'b0;
        for (int i = 0; i < r; i++)
          for (int j = 0; j < c; j++) begin
            if (!sym_mat[i][j]) continue;
            for (int di = -1; di <= 1; di++)
              for (int dj = -1; dj <= 1; dj++) begin
                ip = i + di;
                jp = j + dj;
                if (di == 0 && dj == 0) continue;
                if (ip < 0 || jp < 0 || ip >= r || jp >= c) continue;
                uni = (src_mat[ip] | tgt_mat[ip]) & mask;
                if ((!row_flags[ip] || !col_flags[jp]) && uni[jp]) mark_cell(ip, jp);
              end
          end
      end while (grew);
      for (int i = 0; i < r; i++)
        for (int j = 0; j < c; j++)
          if ((!row_flags[i] || !col_flags[j]) && src_mat[i][j]) mark_cell(i, j);
      for (int i = 0; i < r; i++)
        for (int j = 0; j < c; j++)
          if ((!row_flags[i] || !col_flags[j]) && tgt_mat[i][j]) mark_cell(i, j);
    end
    for (int k = 0; k < r; k++) begin
      er.result_row  = sym_mat[k] & mask;
      er.row_index   = 5'(k);
      er.last_of_run = (k + 1 == r);
      expected_rows  = {expected_rows, er};
    end
  endfunction

  function automatic void accept_row_pair(input row_pair_t p);
    if (load_count < 32) begin
      src_mat[load_count] = p.source_row;
      tgt_mat[load_count] = p.target_row;
      load_count++;
    end
    if (p.final_row) begin
      load_count = 0;
      symmetrize_run();
    end
  endfunction

  // driver: row pairs from the pending queue, random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accept_row_pair('{in_ch.source_row, in_ch.target_row, in_ch.final_row});
        void'(pending_rows.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if ((!in_ch.valid || in_ch.ready) && !calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
      end else if (pending_rows.size() > 0 && (!in_ch.valid || !in_ch.ready)) begin
        in_ch.valid      <= 1'b1;
        in_ch.source_row <= pending_rows[0].source_row;
        in_ch.target_row <= pending_rows[0].target_row;
        in_ch.final_row  <= pending_rows[0].final_row;
      end else if (in_ch.valid && in_ch.ready) begin
        // previous item went in; present the next one or drop valid
        if (pending_rows.size() > 0) begin
          in_ch.source_row <= pending_rows[0].source_row;
          in_ch.target_row <= pending_rows[0].target_row;
          in_ch.final_row  <= pending_rows[0].final_row;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls on ready, compares each result row
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          report_mismatch("result row with nothing expected");
        end else begin
          sym_row_t e;
          e = expected_rows.pop_front();
          if (out_ch.result_row !== e.result_row)
            report_mismatch($sformatf("result_row %h expected %h", out_ch.result_row,
                                      e.result_row));
          if (out_ch.row_index !== e.row_index)
            report_mismatch($sformatf("row_index %0d expected %0d", out_ch.row_index,
                                      e.row_index));
          if (out_ch.last_of_run !== e.last_of_run)
            report_mismatch($sformatf("last_of_run %b expected %b", out_ch.last_of_run,
                                      e.last_of_run));
          if (e.last_of_run) runs_seen++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // configuration write; callers use it only while the block is idle, the task does not enforce it
  task automatic write_reg(input cfg_reg_t idx, input logic [5:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ROWS:   cur_rows = val;
      REG_COLS:   cur_cols = val;
      REG_METHOD: cur_method = method_t'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_rows.size() > 0 || expected_rows.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_shape(input int r, input int c, input method_t m);
    write_reg(REG_ROWS, 6'(r));
    write_reg(REG_COLS, 6'(c));
    write_reg(REG_METHOD, 6'(m));
  endtask

  // one matrix: r row pairs, the last flagged final; density sets fill level
  task automatic queue_matrix(input int r, input int density);
    row_pair_t p;
    logic [31:0] base;
    for (int i = 0; i < r; i++) begin
      case (density)
        0: begin p.source_row = '0; p.target_row = '0; end
        1: begin p.source_row = '1; p.target_row = '1; end
        2: begin // near-diagonal alignments sharing much of their content
          base = (32'd1 << (i % 32)) | (32'd1 << ($urandom_range(0, 31)));
          p.source_row = base | ($urandom_range(0, 3) == 0 ? $urandom : 32'd0);
          p.target_row = base ^ ($urandom_range(0, 2) == 0 ? (32'd1 << $urandom_range(0, 31)) : 0);
        end
        default: begin
          p.source_row = $urandom & $urandom;
          p.target_row = $urandom & $urandom;
        end
      endcase
      p.final_row = (i == r - 1);
      pending_rows = {pending_rows, p};
    end
  endtask

  int shape_r, shape_c, total_items;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.source_row = '0;
    in_ch.target_row = '0;
    in_ch.final_row = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROWS;
    cfg_ch.data = '0;
    cur_rows = 6'd32;
    cur_cols = 6'd32;
    cur_method = METH_GDF;
    load_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a four-row shape, empty and full matrices, each method, tiny shapes
    set_shape(4, 32, METH_GDF);
    queue_matrix(4, 2);
    wait_idle();
    queue_matrix(4, 0);
    queue_matrix(4, 1);
    wait_idle();
    set_shape(1, 1, METH_REFINED);
    queue_matrix(1, 1);
    wait_idle();
    set_shape(3, 5, METH_REF_EXC);
    queue_matrix(3, 1);
    queue_matrix(3, 3);
    wait_idle();
    // out-of-range sizes and the spare method code
    set_shape(0, 63, METH_ALT_GDF);
    queue_matrix(1, 3);
    wait_idle();
    // surplus rows past the maximum are dropped by the loader
    set_shape(32, 32, METH_GDF);
    queue_matrix(34, 2);
    wait_idle();

    total_items = 0;
    while (total_items < 355) begin
      shape_r = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 8);
      shape_c = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 12);
      set_shape(shape_r, shape_c, method_t'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 4)) begin
        queue_matrix(shape_r, $urandom_range(0, 5) < 2 ? $urandom_range(0, 1) :
                                $urandom_range(2, 3));
        total_items += shape_r;
      end
      if (total_items > 300) calm = 1'b1;
      wait_idle();
    end
    repeat (200) @(posedge clk);
    $display("covered %0d result rows over %0d symmetrized matrices, all methods",
             rows_seen, runs_seen);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
